@@ sv/jsi_pkg.sv @@
// Shared types, constants and helpers for the JSON structural indexer.
// No dependencies; every module of the block imports this package.
package jsi_pkg;

  localparam int BYTES_PER_ITEM = 8;
  localparam int OFFSET_WIDTH   = 32;
  localparam int IDX_W  = (BYTES_PER_ITEM > 1) ? $clog2(BYTES_PER_ITEM) : 1;
  localparam int POP_W  = $clog2(BYTES_PER_ITEM + 1);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [31:0] offset_value;
    logic        is_count;
    logic        last_of_item;
  } out_item_t;

  // One classified input item waiting for the back end.
  typedef struct packed {
    logic [BYTES_PER_ITEM-1:0] mask;
    logic [OFFSET_WIDTH-1:0]   base;
    logic                      eos;
    logic [OFFSET_WIDTH-1:0]   total;
  } entry_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [FIFO_AW:0]   level;
  } fifo_status_t;

  function automatic logic is_structural(input logic [7:0] b);
    return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_LBRACK) ||
           (b == CH_RBRACK) || (b == CH_COMMA) || (b == CH_COLON);
  endfunction

endpackage

@@ sv/jsi_front.sv @@
// Front end: scans the bytes of an accepted item and builds a queue entry.
// Holds the string, escape, position and count state. Depends on jsi_pkg.
module jsi_front import jsi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  in_item_t in_item,
  input  logic     in_accept,
  output entry_t   ent,
  output logic     ent_push
);

  logic                      ins_r, ins_nxt;
  logic                      bs_r, bs_nxt;
  logic [OFFSET_WIDTH-1:0]   pos_r, pos_nxt;
  logic [OFFSET_WIDTH-1:0]   total_r, total_nxt;
  logic [BYTES_PER_ITEM-1:0] mask;
  logic [POP_W-1:0]          pc;
  logic [3:0]                cnt;
  logic                      ins_s, bs_s;
  logic [OFFSET_WIDTH:0]     sum;
  logic [OFFSET_WIDTH-1:0]   total_sat;

  always_comb begin
    logic [7:0] b;
    b = '0;
    if (in_item.byte_count > 4'(BYTES_PER_ITEM)) begin
      cnt = 4'(BYTES_PER_ITEM);
    end else begin
      cnt = in_item.byte_count;
    end
    ins_s = ins_r;
    bs_s  = bs_r;
    mask  = '0;
    pc    = '0;
    // Escapes count only inside a string; outside, a backslash is plain.
    for (int i = 0; i < BYTES_PER_ITEM; i++) begin
      b = in_item.data_word[8*i +: 8];
      if (4'(i) < cnt) begin
        if (ins_s) begin
          if (bs_s) begin
            bs_s = 1'b0;
          end else if (b == CH_BSLASH) begin
            bs_s = 1'b1;
          end else if (b == CH_QUOTE) begin
            ins_s = 1'b0;
          end
        end else if (b == CH_QUOTE) begin
          ins_s   = 1'b1;
          mask[i] = 1'b1;
        end else if (is_structural(b)) begin
          mask[i] = 1'b1;
        end
      end
      pc = pc + POP_W'(mask[i]);
    end
    sum       = {1'b0, total_r} + (OFFSET_WIDTH + 1)'(pc);
    total_sat = sum[OFFSET_WIDTH] ? '1 : sum[OFFSET_WIDTH-1:0];
  end

  always_comb begin
    ins_nxt   = ins_r;
    bs_nxt    = bs_r;
    pos_nxt   = pos_r;
    total_nxt = total_r;
    if (in_accept) begin
      if (in_item.end_of_stream) begin
        ins_nxt   = 1'b0;
        bs_nxt    = 1'b0;
        pos_nxt   = '0;
        total_nxt = '0;
      end else begin
        ins_nxt   = ins_s;
        bs_nxt    = bs_s;
        pos_nxt   = pos_r + OFFSET_WIDTH'(cnt);
        total_nxt = total_sat;
      end
    end
  end

  assign ent.mask  = mask;
  assign ent.base  = pos_r;
  assign ent.eos   = in_item.end_of_stream;
  assign ent.total = total_sat;
  assign ent_push  = in_accept && ((pc != '0) || in_item.end_of_stream);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ins_r   <= 1'b0;
      bs_r    <= 1'b0;
      pos_r   <= '0;
      total_r <= '0;
    end else begin
      ins_r   <= ins_nxt;
      bs_r    <= bs_nxt;
      pos_r   <= pos_nxt;
      total_r <= total_nxt;
    end
  end

endmodule

@@ sv/jsi_fifo.sv @@
// Short queue of classified entries between the front and back ends.
// Depends on jsi_pkg for the entry type and depth.
module jsi_fifo import jsi_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  entry_t       wr_ent,
  input  logic         wr_en,
  output entry_t       rd_ent,
  input  logic         rd_en,
  output fifo_status_t status
);

  entry_t             mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, wp_nxt;
  logic [FIFO_AW-1:0] rp_r, rp_nxt;
  logic [FIFO_AW:0]   lvl_r, lvl_nxt;

  always_comb begin
    wp_nxt  = wr_en ? wp_r + 1'b1 : wp_r;
    rp_nxt  = rd_en ? rp_r + 1'b1 : rp_r;
    lvl_nxt = lvl_r + (FIFO_AW + 1)'(wr_en) - (FIFO_AW + 1)'(rd_en);
  end

  assign rd_ent       = mem_r[rp_r];
  assign status.full  = (lvl_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign status.empty = (lvl_r == '0);
  assign status.level = lvl_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      lvl_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      lvl_r <= lvl_nxt;
    end
  end

endmodule

@@ sv/jsi_back.sv @@
// Back end: expands one queue entry into offset results, one per cycle while
// the output is free, then the count result at end of stream. Depends on jsi_pkg.
module jsi_back import jsi_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  entry_t       head,
  input  fifo_status_t fst,
  output logic         head_pop,
  output out_item_t    out_item,
  output logic         out_empty,
  input  logic         out_pop
);

  logic                      cur_valid_r;
  logic [BYTES_PER_ITEM-1:0] cur_mask_r, mask_left;
  logic [OFFSET_WIDTH-1:0]   cur_base_r;
  logic                      cur_eos_r;
  logic [OFFSET_WIDTH-1:0]   cur_total_r;
  logic                      out_valid_r;
  out_item_t                 out_item_r, res;
  logic                      adv, finish, cur_free;
  logic [IDX_W-1:0]          idx;

  always_comb begin
    idx = '0;
    for (int i = BYTES_PER_ITEM - 1; i >= 0; i--) begin
      if (cur_mask_r[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

  // Clearing the lowest set bit leaves the offsets still to go.
  assign mask_left = cur_mask_r & (cur_mask_r - 1'b1);
  assign adv       = cur_valid_r && (!out_valid_r || out_pop);

  always_comb begin
    if (cur_mask_r != '0) begin
      res.offset_value = 32'(cur_base_r + OFFSET_WIDTH'(idx));
      res.is_count     = 1'b0;
      res.last_of_item = (mask_left == '0) && !cur_eos_r;
      finish           = (mask_left == '0) && !cur_eos_r;
    end else begin
      res.offset_value = 32'(cur_total_r);
      res.is_count     = 1'b1;
      res.last_of_item = 1'b1;
      finish           = 1'b1;
    end
  end

  assign cur_free  = !cur_valid_r || (adv && finish);
  assign head_pop  = !fst.empty && cur_free;
  assign out_item  = out_item_r;
  assign out_empty = !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (head_pop) begin
        cur_valid_r <= 1'b1;
      end else if (adv && finish) begin
        cur_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      cur_mask_r  <= head.mask;
      cur_base_r  <= head.base;
      cur_eos_r   <= head.eos;
      cur_total_r <= head.total;
    end else if (adv) begin
      cur_mask_r <= mask_left;
    end
    if (adv) begin
      out_item_r <= res;
    end
  end

endmodule

@@ sv/json_structural_indexer.sv @@
// Top level of the JSON structural indexer: front end, entry queue, back end.
// Depends on jsi_pkg, jsi_front, jsi_fifo and jsi_back.
//
// The block takes one item of up to eight text bytes in every cycle while
// in_full is low; the front end classifies all bytes of an item in that
// cycle and queues one entry (items that yield nothing are not queued).
// The back end delivers one result per cycle while the output register is
// empty or popped, so an item holds the back end until all its results (its
// offsets, plus the count at end of stream) are out, and the sustained rate
// is set by that output register. A four-entry queue absorbs bursts; each
// result passes the queue, the current-entry register and the output register.
module json_structural_indexer import jsi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  logic      in_push,
  output logic      in_full,
  output out_item_t out_item,
  output logic      out_empty,
  input  logic      out_pop
);

  logic         in_accept;
  entry_t       ent, head;
  logic         ent_push, head_pop;
  fifo_status_t fst;

  assign in_full   = fst.full;
  assign in_accept = in_push && !in_full;

  jsi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .in_accept (in_accept),
    .ent       (ent),
    .ent_push  (ent_push)
  );

  jsi_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_ent (ent),
    .wr_en  (ent_push),
    .rd_ent (head),
    .rd_en  (head_pop),
    .status (fst)
  );

  jsi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .fst       (fst),
    .head_pop  (head_pop),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

  // The count result always closes its item.
  a_count_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.is_count) |-> out_item.last_of_item)
    else $error("count result without last_of_item");

  // Only entries that carry work are queued.
  a_entry_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    ent_push |-> ((ent.mask != '0) || ent.eos))
    else $error("empty entry queued");

  // The queue level moves by at most one per cycle.
  a_level_step: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> ((fst.level == $past(fst.level)) ||
               (fst.level == $past(fst.level) + 1'b1) ||
               (fst.level == $past(fst.level) - 1'b1)))
    else $error("queue level jumped");

endmodule

@@ test/tb_json_structural_indexer.sv @@
// Self-checking testbench for json_structural_indexer: a directed table, then random text.
// Every result is checked against an in-bench scanner of structural offsets or a typed table row.
// Depends on jsi_pkg and the json_structural_indexer RTL.
module tb_json_structural_indexer;
  import jsi_pkg::*;

  localparam int DIR_N     = 19;
  localparam int RAND_N    = 211;
  localparam int HOLD_LEN  = 300;
  localparam int LIMIT     = 200000;
  localparam int SHOW_MAX  = 10;

  logic      clk = 1'b0;
  logic      rst_n;
  in_item_t  in_item;
  logic      in_push;
  logic      in_full;
  out_item_t out_item;
  logic      out_empty;
  logic      out_pop;

  json_structural_indexer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .in_push  (in_push),
    .in_full  (in_full),
    .out_item (out_item),
    .out_empty(out_empty),
    .out_pop  (out_pop)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        eos;
    bit          typed;
    int          n_typed;
    out_item_t   typed_res;
  } dir_row_t;

  dir_row_t  dir_tab[DIR_N];

  // Scanner state, mirrored from the block.
  logic        in_str;
  logic        esc;
  logic [31:0] pos;
  logic [31:0] total;

  out_item_t   batch[$];
  out_item_t   offsets_due[$];
  out_item_t   head;
  int          errs = 0;
  int          cycle_cnt = 0;
  int          send_gap_pct;
  int          recv_gap_pct;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  function automatic logic [63:0] txt(input string s);
    logic [63:0] w;
    w = '0;
    for (int k = 0; k < s.len() && k < 8; k++) w[8*k +: 8] = s[k];
    return w;
  endfunction

  // Works out the results of one item and advances the scanner state.
  function automatic void scan_item(input in_item_t it);
    int          n_bytes;
    logic [7:0]  ch;
    logic        hit;
    out_item_t   r;
    batch.delete();
    n_bytes = (it.byte_count > BYTES_PER_ITEM) ? BYTES_PER_ITEM : int'(it.byte_count);
    for (int k = 0; k < n_bytes; k++) begin
      ch  = it.data_word[8*k +: 8];
      hit = 1'b0;
      if (in_str) begin
        if (esc) esc = 1'b0;
        else if (ch == CH_BSLASH) esc = 1'b1;
        else if (ch == CH_QUOTE) in_str = 1'b0;
      end else if (ch == CH_QUOTE) begin
        in_str = 1'b1;
        hit    = 1'b1;
      end else if (ch == CH_LBRACE || ch == CH_RBRACE || ch == CH_LBRACK ||
                   ch == CH_RBRACK || ch == CH_COMMA || ch == CH_COLON) begin
        hit = 1'b1;
      end
      if (hit) begin
        r = '{offset_value: pos, is_count: 1'b0, last_of_item: 1'b0};
        batch.push_back(r);
        if (total != '1) total = total + 1;
      end
      pos = pos + 1;
    end
    if (it.end_of_stream) begin
      r = '{offset_value: total, is_count: 1'b1, last_of_item: 1'b0};
      batch.push_back(r);
      in_str = 1'b0;
      esc    = 1'b0;
      pos    = '0;
      total  = '0;
    end
    if (batch.size() > 0) batch[batch.size()-1].last_of_item = 1'b1;
  endfunction

  function automatic logic [7:0] json_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      case ($urandom_range(0, 5))
        0: return CH_LBRACE;
        1: return CH_RBRACE;
        2: return CH_LBRACK;
        3: return CH_RBRACK;
        4: return CH_COMMA;
        default: return CH_COLON;
      endcase
    end
    if (r < 45) return CH_QUOTE;
    if (r < 52) return CH_BSLASH;
    if (r < 62) return 8'h20;
    if (r < 90) return 8'($urandom_range(8'h30, 8'h7A));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       r;
    for (int k = 0; k < 8; k++) it.data_word[8*k +: 8] = json_byte();
    r = $urandom_range(0, 99);
    if (r < 75) it.byte_count = 4'd8;
    else if (r < 90) it.byte_count = 4'($urandom_range(1, 7));
    else if (r < 95) it.byte_count = 4'd0;
    else it.byte_count = 4'($urandom_range(9, 15));
    it.end_of_stream = ($urandom_range(0, 9) == 0);
    return it;
  endfunction

  // Offers one item; the results in batch become due once the item is taken.
  task automatic offer(input in_item_t it);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    foreach (batch[j]) offsets_due.push_back(batch[j]);
    @(negedge clk);
  endtask

  task automatic report(input string what, input out_item_t want, input out_item_t got);
    errs++;
    if (errs <= SHOW_MAX)
      $display({"cycle %0d: %s: expected offset=%0d count=%0b last=%0b, ",
                "got offset=%0d count=%0b last=%0b"},
               cycle_cnt, what, want.offset_value, want.is_count, want.last_of_item,
               got.offset_value, got.is_count, got.last_of_item);
  endtask

  // Receiver: random pops, plus one long hold-off when asked for.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_LEN;
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (offsets_due.size() == 0) begin
        report("result with nothing expected", '0, out_item);
      end else begin
        head = offsets_due.pop_front();
        if (out_item.offset_value !== head.offset_value ||
            out_item.is_count !== head.is_count ||
            out_item.last_of_item !== head.last_of_item)
          report("mismatch", head, out_item);
      end
    end
  end

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_json_structural_indexer: done, errors");
    $finish;
  end

  initial begin
    in_item_t it;
    rst_n   = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    out_pop = 1'b0;
    in_str  = 1'b0;
    esc     = 1'b0;
    pos     = '0;
    total   = '0;
    send_gap_pct = 20;
    recv_gap_pct = 64;

    // Rows whose results are obvious carry them; the rest go through the scanner.
    dir_tab[0]  = '{txt(""), 4'd0, 1'b1, 1'b1, 1, '{32'd0, 1'b1, 1'b1}};
    dir_tab[1]  = '{txt("{"), 4'd1, 1'b0, 1'b1, 1, '{32'd0, 1'b0, 1'b1}};
    dir_tab[2]  = '{txt("]]]]]]]]"), 4'd0, 1'b0, 1'b1, 0, '0};
    dir_tab[3]  = '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 1'b1, 0, '0};
    dir_tab[4]  = '{64'h0, 4'd8, 1'b0, 1'b1, 0, '0};
    dir_tab[5]  = '{txt(""), 4'd0, 1'b1, 1'b1, 1, '{32'd1, 1'b1, 1'b1}};
    dir_tab[6]  = '{txt("{}[],:ab"), 4'd8, 1'b0, 1'b0, 0, '0};
    dir_tab[7]  = '{txt("\"a,b\\\"}\""), 4'd8, 1'b0, 1'b0, 0, '0};
    // A backslash outside a string does not hide the quote after it.
    dir_tab[8]  = '{txt("\\\"x\":1,"), 4'd7, 1'b0, 1'b0, 0, '0};
    dir_tab[9]  = '{txt("\"abcdef\\"), 4'd8, 1'b0, 1'b0, 0, '0};
    dir_tab[10] = '{txt("\",:\"]"), 4'd5, 1'b0, 1'b0, 0, '0};
    dir_tab[11] = '{txt("[[[[[[[["), 4'd15, 1'b0, 1'b0, 0, '0};
    dir_tab[12] = '{txt(",,,,,,,,"), 4'd9, 1'b0, 1'b0, 0, '0};
    dir_tab[13] = '{txt("{:}\"abc"), 4'd3, 1'b0, 1'b0, 0, '0};
    dir_tab[14] = '{txt("\"open{,"), 4'd7, 1'b1, 1'b0, 0, '0};
    dir_tab[15] = '{txt("{}{}{}{}"), 4'd8, 1'b1, 1'b0, 0, '0};
    dir_tab[16] = '{txt("\"\\\\\"]"), 4'd5, 1'b1, 1'b0, 0, '0};
    dir_tab[17] = '{64'h7B7D_5B5D_2C3A_225C, 4'd8, 1'b1, 1'b0, 0, '0};
    dir_tab[18] = '{64'h5C22_3A2C_5D5B_7D7B, 4'd8, 1'b1, 1'b0, 0, '0};

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < DIR_N; r++) begin
      it = '{data_word: dir_tab[r].data, byte_count: dir_tab[r].cnt,
             end_of_stream: dir_tab[r].eos};
      scan_item(it);
      if (dir_tab[r].typed) begin
        batch.delete();
        if (dir_tab[r].n_typed == 1) batch.push_back(dir_tab[r].typed_res);
      end
      offer(it);
    end

    // Offset wrap and count saturation need 2^32 bytes, far beyond this run.
    for (int n = 0; n < RAND_N; n++) begin
      if (n == RAND_N / 3) begin
        send_gap_pct = 64;
        recv_gap_pct = 20;
      end else if (n == 2 * RAND_N / 3) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
        hold_req++;
      end
      it = random_item();
      scan_item(it);
      offer(it);
    end
    in_push <= 1'b0;

    while (offsets_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errs == 0)
      $display("tb_json_structural_indexer: done, clean");
    else
      $display("tb_json_structural_indexer: done, errors");
    $finish;
  end

endmodule

@@ sim.f @@
sv/jsi_pkg.sv
sv/jsi_front.sv
sv/jsi_fifo.sv
sv/jsi_back.sv
sv/json_structural_indexer.sv
test/tb_json_structural_indexer.sv
